FILE: sv/hfs_pkg.sv
package hfs_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned StepW = 2;
  localparam int unsigned TimeW = 32;
  localparam int unsigned LevelW = 8;
  localparam int unsigned DurW = 16;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [FuncW-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FuncW-1:0] FUNC_DOUBLE = 3'd1;
  localparam logic [FuncW-1:0] FUNC_BUTTON = 3'd2;
  localparam logic [FuncW-1:0] FUNC_LONG   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_FAIL   = 3'd4;
  localparam logic [FuncW-1:0] FUNC_CALIB  = 3'd5;
  localparam logic [FuncW-1:0] FUNC_STOP   = 3'd6;

  localparam logic [FuncW-1:0] CUE_NONE   = 3'd0;
  localparam logic [FuncW-1:0] CUE_DOUBLE = 3'd1;
  localparam logic [FuncW-1:0] CUE_BUTTON = 3'd2;
  localparam logic [FuncW-1:0] CUE_LONG   = 3'd3;
  localparam logic [FuncW-1:0] CUE_FAIL   = 3'd4;
  localparam logic [FuncW-1:0] CUE_CALIB  = 3'd5;

  localparam logic [StepW-1:0] STEP_0 = 2'd0;
  localparam logic [StepW-1:0] STEP_1 = 2'd1;
  localparam logic [StepW-1:0] STEP_2 = 2'd2;
  localparam logic [StepW-1:0] STEP_3 = 2'd3;

  localparam logic [TimeW-1:0] T_DBL_OFF1  = 32'd150;
  localparam logic [TimeW-1:0] T_DBL_ON2   = 32'd300;
  localparam logic [TimeW-1:0] T_DBL_OFF2  = 32'd450;
  localparam logic [TimeW-1:0] T_BTN_MOTOR = 32'd30;
  localparam logic [TimeW-1:0] T_BTN_LED   = 32'd90;
  localparam logic [TimeW-1:0] T_FAIL_END  = 32'd1200;
  localparam logic [TimeW-1:0] T_CAL_MOTOR = 32'd150;
  localparam logic [TimeW-1:0] T_CAL_LED   = 32'd210;

  localparam logic [LevelW-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LevelW-1:0] LEVEL_OFF  = 8'd0;

  localparam logic [CfgIdxW-1:0] REG_LOW_LEVEL    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HIGH_LEVEL   = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LEVEL    = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LONG_BUZZ_MS = 8'd3;

  localparam logic [LevelW-1:0] RST_LOW_LEVEL    = 8'd128;
  localparam logic [LevelW-1:0] RST_HIGH_LEVEL   = 8'd200;
  localparam logic [LevelW-1:0] RST_MAX_LEVEL    = 8'd255;
  localparam logic [DurW-1:0]   RST_LONG_BUZZ_MS = 16'd500;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [TimeW-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [LevelW-1:0] motor_level;
    logic              blue_led;
    logic              error_led;
    logic              busy_res;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [DurW-1:0]    value;
  } cfg_wr_t;

  typedef struct packed {
    logic [LevelW-1:0] low_level;
    logic [LevelW-1:0] high_level;
    logic [LevelW-1:0] max_level;
    logic [DurW-1:0]   long_buzz_ms;
  } cfg_t;

endpackage

FILE: sv/hfs_chan_if.sv
interface hfs_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/haptic_feedback_sequencer_core.sv
// Path: input register (s1), then result register; a result stall holds both.
// Throughput: one command per cycle while res.ready keeps up; each cue step is a single
// 32-bit subtract and compare against the cue state registers, updated in the same
// cycle the result is registered. Reset (rst, synchronous): no cue active, outputs
// off, registers at defaults (128, 200, 255, 500 ms); both pipeline stages empty.
module haptic_feedback_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  hfs_chan_if.sink   cmd,
  hfs_chan_if.source res,
  hfs_chan_if.sink   cfg
);

  logic          s1_valid;
  hfs_pkg::cmd_t s1_cmd;
  logic          adv;
  hfs_pkg::cfg_t regs;
  hfs_pkg::res_t res_next;
  hfs_pkg::res_t res_data;
  logic          res_valid;

  assign adv       = s1_valid && (!res_valid || res.ready);
  assign cmd.ready = !s1_valid || adv;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  hfs_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg.valid),
    .wr    (cfg.data),
    .regs  (regs)
  );

  hfs_cue_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (adv),
    .cmd      (s1_cmd),
    .cfg      (regs),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_cmd <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data <= res_next;
    end
  end

endmodule

FILE: sv/hfs_cfg_regs.sv
module hfs_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  hfs_pkg::cfg_wr_t wr,
  output hfs_pkg::cfg_t   regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_level    <= hfs_pkg::RST_LOW_LEVEL;
      regs.high_level   <= hfs_pkg::RST_HIGH_LEVEL;
      regs.max_level    <= hfs_pkg::RST_MAX_LEVEL;
      regs.long_buzz_ms <= hfs_pkg::RST_LONG_BUZZ_MS;
    end else if (wr_en) begin
      unique case (wr.index)
        hfs_pkg::REG_LOW_LEVEL:    regs.low_level    <= wr.value[hfs_pkg::LevelW-1:0];
        hfs_pkg::REG_HIGH_LEVEL:   regs.high_level   <= wr.value[hfs_pkg::LevelW-1:0];
        hfs_pkg::REG_MAX_LEVEL:    regs.max_level    <= wr.value[hfs_pkg::LevelW-1:0];
        hfs_pkg::REG_LONG_BUZZ_MS: regs.long_buzz_ms <= wr.value;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/hfs_cue_engine.sv
module hfs_cue_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  hfs_pkg::cmd_t               cmd,
  input  hfs_pkg::cfg_t               cfg,
  output hfs_pkg::res_t               res_next
);

  logic [hfs_pkg::FuncW-1:0]  active_cue, active_cue_next;
  logic [hfs_pkg::StepW-1:0]  cue_step, cue_step_next;
  logic [hfs_pkg::TimeW-1:0]  cue_start_time, cue_start_time_next;
  logic [hfs_pkg::LevelW-1:0] motor_hold, motor_hold_next;
  logic                       blue_hold, blue_hold_next;
  logic                       error_hold, error_hold_next;
  logic                       busy_flag, busy_flag_next;

  logic                       is_start;
  logic                       do_adv;
  logic [hfs_pkg::FuncW-1:0]  cur_cue;
  logic [hfs_pkg::StepW-1:0]  cur_step;
  logic [hfs_pkg::TimeW-1:0]  el;

  assign is_start = (cmd.func >= hfs_pkg::FUNC_DOUBLE) && (cmd.func <= hfs_pkg::FUNC_CALIB);
  assign do_adv   = is_start || (cmd.func == hfs_pkg::FUNC_TICK);
  assign cur_cue  = is_start ? cmd.func : active_cue;
  assign cur_step = is_start ? hfs_pkg::STEP_0 : cue_step;
  assign el       = cmd.now_ms - cue_start_time;

  always_comb begin
    active_cue_next     = active_cue;
    cue_step_next       = cue_step;
    cue_start_time_next = cue_start_time;
    motor_hold_next     = motor_hold;
    blue_hold_next      = blue_hold;
    error_hold_next     = error_hold;
    busy_flag_next      = busy_flag;

    if (is_start) begin
      busy_flag_next      = 1'b1;
      active_cue_next     = cmd.func;
      cue_start_time_next = cmd.now_ms;
      cue_step_next       = hfs_pkg::STEP_0;
    end

    if (cmd.func == hfs_pkg::FUNC_STOP) begin
      active_cue_next = hfs_pkg::CUE_NONE;
      cue_step_next   = hfs_pkg::STEP_0;
      busy_flag_next  = 1'b0;
      motor_hold_next = hfs_pkg::LEVEL_OFF;
      error_hold_next = 1'b0;
      blue_hold_next  = 1'b0;
    end else if (do_adv && (cur_cue != hfs_pkg::CUE_NONE)) begin
      case (cur_cue)
        hfs_pkg::CUE_DOUBLE: begin
          if (cur_step == hfs_pkg::STEP_0) begin
            motor_hold_next = cfg.low_level;
            blue_hold_next  = 1'b1;
            cue_step_next   = hfs_pkg::STEP_1;
          end else if (cur_step == hfs_pkg::STEP_1 && el >= hfs_pkg::T_DBL_OFF1) begin
            motor_hold_next = hfs_pkg::LEVEL_OFF;
            blue_hold_next  = 1'b0;
            cue_step_next   = hfs_pkg::STEP_2;
          end else if (cur_step == hfs_pkg::STEP_2 && el >= hfs_pkg::T_DBL_ON2) begin
            motor_hold_next = cfg.low_level;
            blue_hold_next  = 1'b1;
            cue_step_next   = hfs_pkg::STEP_3;
          end else if (cur_step == hfs_pkg::STEP_3 && el >= hfs_pkg::T_DBL_OFF2) begin
            motor_hold_next = hfs_pkg::LEVEL_OFF;
            blue_hold_next  = 1'b0;
            active_cue_next = hfs_pkg::CUE_NONE;
            busy_flag_next  = 1'b0;
          end
        end
        hfs_pkg::CUE_BUTTON: begin
          if (cur_step == hfs_pkg::STEP_0) begin
            motor_hold_next = cfg.low_level;
            blue_hold_next  = 1'b1;
            cue_step_next   = hfs_pkg::STEP_1;
          end else if (cur_step == hfs_pkg::STEP_1 && el >= hfs_pkg::T_BTN_MOTOR) begin
            motor_hold_next = hfs_pkg::LEVEL_OFF;
            cue_step_next   = hfs_pkg::STEP_2;
          end else if (cur_step == hfs_pkg::STEP_2 && el >= hfs_pkg::T_BTN_LED) begin
            blue_hold_next  = 1'b0;
            active_cue_next = hfs_pkg::CUE_NONE;
            busy_flag_next  = 1'b0;
          end
        end
        hfs_pkg::CUE_LONG: begin
          if (cur_step == hfs_pkg::STEP_0) begin
            motor_hold_next = hfs_pkg::LEVEL_FULL;
            blue_hold_next  = 1'b1;
            cue_step_next   = hfs_pkg::STEP_1;
          end else if (cur_step == hfs_pkg::STEP_1 &&
                       el >= {{(hfs_pkg::TimeW-hfs_pkg::DurW){1'b0}}, cfg.long_buzz_ms}) begin
            motor_hold_next = hfs_pkg::LEVEL_OFF;
            blue_hold_next  = 1'b0;
            active_cue_next = hfs_pkg::CUE_NONE;
            busy_flag_next  = 1'b0;
          end
        end
        hfs_pkg::CUE_FAIL: begin
          if (cur_step == hfs_pkg::STEP_0) begin
            motor_hold_next = cfg.high_level;
            error_hold_next = 1'b1;
            cue_step_next   = hfs_pkg::STEP_1;
          end else if (cur_step == hfs_pkg::STEP_1 && el >= hfs_pkg::T_FAIL_END) begin
            motor_hold_next = hfs_pkg::LEVEL_OFF;
            error_hold_next = 1'b0;
            active_cue_next = hfs_pkg::CUE_NONE;
            busy_flag_next  = 1'b0;
          end
        end
        hfs_pkg::CUE_CALIB: begin
          if (cur_step == hfs_pkg::STEP_0) begin
            motor_hold_next = cfg.max_level;
            blue_hold_next  = 1'b1;
            cue_step_next   = hfs_pkg::STEP_1;
          end else if (cur_step == hfs_pkg::STEP_1 && el >= hfs_pkg::T_CAL_MOTOR) begin
            motor_hold_next = hfs_pkg::LEVEL_OFF;
            cue_step_next   = hfs_pkg::STEP_2;
          end else if (cur_step == hfs_pkg::STEP_2 && el >= hfs_pkg::T_CAL_LED) begin
            blue_hold_next  = 1'b0;
            active_cue_next = hfs_pkg::CUE_NONE;
            busy_flag_next  = 1'b0;
          end
        end
        default: begin
          motor_hold_next = hfs_pkg::LEVEL_OFF;
          cue_step_next   = hfs_pkg::STEP_0;
          active_cue_next = hfs_pkg::CUE_NONE;
          busy_flag_next  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cue     <= hfs_pkg::CUE_NONE;
      cue_step       <= hfs_pkg::STEP_0;
      cue_start_time <= '0;
      motor_hold     <= hfs_pkg::LEVEL_OFF;
      blue_hold      <= 1'b0;
      error_hold     <= 1'b0;
      busy_flag      <= 1'b0;
    end else if (fire) begin
      active_cue     <= active_cue_next;
      cue_step       <= cue_step_next;
      cue_start_time <= cue_start_time_next;
      motor_hold     <= motor_hold_next;
      blue_hold      <= blue_hold_next;
      error_hold     <= error_hold_next;
      busy_flag      <= busy_flag_next;
    end
  end

  assign res_next.motor_level = motor_hold_next;
  assign res_next.blue_led    = blue_hold_next;
  assign res_next.error_led   = error_hold_next;
  assign res_next.busy_res    = busy_flag_next;

  a_busy_tracks_cue: assert property (@(posedge clk) disable iff (rst)
    busy_flag == (active_cue != hfs_pkg::CUE_NONE))
    else $error("busy flag out of step with active cue");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.func == hfs_pkg::FUNC_STOP |=>
      motor_hold == hfs_pkg::LEVEL_OFF && !blue_hold && !error_hold && !busy_flag)
    else $error("stop left outputs driven");

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    fire && is_start |=>
      busy_flag && active_cue == $past(cmd.func) && cue_step == hfs_pkg::STEP_1 &&
      cue_start_time == $past(cmd.now_ms))
    else $error("start did not load cue");

endmodule

FILE: bench/hfs_tb_pkg.sv
package hfs_tb_pkg;

  class cue_tracker;
    logic [hfs_pkg::LevelW-1:0] low_level;
    logic [hfs_pkg::LevelW-1:0] high_level;
    logic [hfs_pkg::LevelW-1:0] max_level;
    logic [hfs_pkg::DurW-1:0]   long_buzz_ms;

    logic [hfs_pkg::FuncW-1:0] cue;
    logic [hfs_pkg::StepW-1:0] step;
    logic [hfs_pkg::TimeW-1:0] start_ms;
    hfs_pkg::res_t             held;

    hfs_pkg::res_t pending_outputs[$];
    int unsigned   mismatches;

    function new();
      low_level    = hfs_pkg::RST_LOW_LEVEL;
      high_level   = hfs_pkg::RST_HIGH_LEVEL;
      max_level    = hfs_pkg::RST_MAX_LEVEL;
      long_buzz_ms = hfs_pkg::RST_LONG_BUZZ_MS;
      cue          = hfs_pkg::CUE_NONE;
      step         = hfs_pkg::STEP_0;
      start_ms     = '0;
      held         = '0;
      mismatches   = 0;
    endfunction

    function void write_register(hfs_pkg::cfg_wr_t wr);
      case (wr.index)
        hfs_pkg::REG_LOW_LEVEL:    low_level    = wr.value[hfs_pkg::LevelW-1:0];
        hfs_pkg::REG_HIGH_LEVEL:   high_level   = wr.value[hfs_pkg::LevelW-1:0];
        hfs_pkg::REG_MAX_LEVEL:    max_level    = wr.value[hfs_pkg::LevelW-1:0];
        hfs_pkg::REG_LONG_BUZZ_MS: long_buzz_ms = wr.value;
        default: ;
      endcase
    endfunction

    function void drive(logic [hfs_pkg::LevelW-1:0] level, logic blue);
      held.motor_level = level;
      held.blue_led    = blue;
    endfunction

    function void end_cue();
      cue           = hfs_pkg::CUE_NONE;
      held.busy_res = 1'b0;
    endfunction

    // at most one step per call
    function void advance_cue(logic [hfs_pkg::TimeW-1:0] now);
      logic [hfs_pkg::TimeW-1:0] elapsed;
      elapsed = now - start_ms;
      case (cue)
        hfs_pkg::CUE_DOUBLE: begin
          if (step == hfs_pkg::STEP_0) begin
            drive(low_level, 1'b1);
            step = hfs_pkg::STEP_1;
          end else if (step == hfs_pkg::STEP_1 && elapsed >= hfs_pkg::T_DBL_OFF1) begin
            drive(hfs_pkg::LEVEL_OFF, 1'b0);
            step = hfs_pkg::STEP_2;
          end else if (step == hfs_pkg::STEP_2 && elapsed >= hfs_pkg::T_DBL_ON2) begin
            drive(low_level, 1'b1);
            step = hfs_pkg::STEP_3;
          end else if (step == hfs_pkg::STEP_3 && elapsed >= hfs_pkg::T_DBL_OFF2) begin
            drive(hfs_pkg::LEVEL_OFF, 1'b0);
            end_cue();
          end
        end
        hfs_pkg::CUE_BUTTON: begin
          if (step == hfs_pkg::STEP_0) begin
            drive(low_level, 1'b1);
            step = hfs_pkg::STEP_1;
          end else if (step == hfs_pkg::STEP_1 && elapsed >= hfs_pkg::T_BTN_MOTOR) begin
            held.motor_level = hfs_pkg::LEVEL_OFF;
            step = hfs_pkg::STEP_2;
          end else if (step == hfs_pkg::STEP_2 && elapsed >= hfs_pkg::T_BTN_LED) begin
            held.blue_led = 1'b0;
            end_cue();
          end
        end
        hfs_pkg::CUE_LONG: begin
          if (step == hfs_pkg::STEP_0) begin
            drive(hfs_pkg::LEVEL_FULL, 1'b1);
            step = hfs_pkg::STEP_1;
          end else if (step == hfs_pkg::STEP_1 &&
                       elapsed >= {{(hfs_pkg::TimeW-hfs_pkg::DurW){1'b0}}, long_buzz_ms}) begin
            drive(hfs_pkg::LEVEL_OFF, 1'b0);
            end_cue();
          end
        end
        hfs_pkg::CUE_FAIL: begin
          if (step == hfs_pkg::STEP_0) begin
            held.motor_level = high_level;
            held.error_led   = 1'b1;
            step = hfs_pkg::STEP_1;
          end else if (step == hfs_pkg::STEP_1 && elapsed >= hfs_pkg::T_FAIL_END) begin
            held.motor_level = hfs_pkg::LEVEL_OFF;
            held.error_led   = 1'b0;
            end_cue();
          end
        end
        hfs_pkg::CUE_CALIB: begin
          if (step == hfs_pkg::STEP_0) begin
            drive(max_level, 1'b1);
            step = hfs_pkg::STEP_1;
          end else if (step == hfs_pkg::STEP_1 && elapsed >= hfs_pkg::T_CAL_MOTOR) begin
            held.motor_level = hfs_pkg::LEVEL_OFF;
            step = hfs_pkg::STEP_2;
          end else if (step == hfs_pkg::STEP_2 && elapsed >= hfs_pkg::T_CAL_LED) begin
            held.blue_led = 1'b0;
            end_cue();
          end
        end
        default: ;
      endcase
    endfunction

    function void note_command(hfs_pkg::cmd_t c);
      case (c.func) inside
        hfs_pkg::FUNC_TICK: advance_cue(c.now_ms);
        [hfs_pkg::FUNC_DOUBLE:hfs_pkg::FUNC_CALIB]: begin
          held.busy_res = 1'b1;
          cue      = c.func;
          start_ms = c.now_ms;
          step     = hfs_pkg::STEP_0;
          advance_cue(c.now_ms);
        end
        hfs_pkg::FUNC_STOP: begin
          cue  = hfs_pkg::CUE_NONE;
          step = hfs_pkg::STEP_0;
          held = '0;
        end
        default: ;
      endcase
      pending_outputs.push_back(held);
    endfunction

    function void report(string what, hfs_pkg::res_t want, hfs_pkg::res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected %0d/%b/%b/%b got %0d/%b/%b/%b",
                 $time, what, want.motor_level, want.blue_led, want.error_led, want.busy_res,
                 got.motor_level, got.blue_led, got.error_led, got.busy_res);
    endfunction

    function void check_output(hfs_pkg::res_t got);
      hfs_pkg::res_t want;
      if (pending_outputs.size() == 0) begin
        report("result with no transaction pending", 'x, got);
        return;
      end
      want = pending_outputs.pop_front();
      if (got.motor_level !== want.motor_level || got.blue_led !== want.blue_led ||
          got.error_led !== want.error_led || got.busy_res !== want.busy_res)
        report("output mismatch", want, got);
    endfunction

    function void close_out();
      if (pending_outputs.size() != 0) begin
        mismatches += pending_outputs.size();
        $display("%0d expected results never arrived", pending_outputs.size());
      end
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hfs_pkg::FuncW-1:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned GAP_MAX       = 11;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 190;
  localparam int unsigned TIMEOUT_NS    = 10_000_000;

  logic clk = 1'b0;
  logic rst;

  hfs_chan_if #(.payload_t(hfs_pkg::cmd_t))    cmd_ch ();
  hfs_chan_if #(.payload_t(hfs_pkg::res_t))    res_ch ();
  hfs_chan_if #(.payload_t(hfs_pkg::cfg_wr_t)) cfg_ch ();

  haptic_feedback_sequencer_core u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  hfs_tb_pkg::cue_tracker    tracker;
  bit                        quiet;
  bit                        hold_req;
  logic [hfs_pkg::TimeW-1:0] clock_ms;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // inputs only move at rising edges, so the negative edge sees what the next
  // rising edge will accept
  always @(negedge clk) begin
    if (rst === 1'b0) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.write_register(cfg_ch.data);
      if (cmd_ch.valid && cmd_ch.ready) tracker.note_command(cmd_ch.data);
      if (res_ch.valid && res_ch.ready) tracker.check_output(res_ch.data);
    end
  end

  function automatic int unsigned pick_wait();
    return quiet ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  task automatic send_cmd(input logic [hfs_pkg::FuncW-1:0] func,
                          input logic [hfs_pkg::TimeW-1:0] now);
    int unsigned gap;
    hfs_pkg::cmd_t item;
    gap = pick_wait();
    item.func = func;
    item.now_ms = now;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.data  <= item;
    cmd_ch.valid <= 1'b1;
    do @(negedge clk); while (!cmd_ch.ready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [hfs_pkg::CfgIdxW-1:0] index,
                           input logic [hfs_pkg::DurW-1:0] value);
    int unsigned gap;
    hfs_pkg::cfg_wr_t wr;
    gap = pick_wait();
    wr.index = index;
    wr.value = value;
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.data  <= wr;
    cfg_ch.valid <= 1'b1;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [hfs_pkg::DurW-1:0] low,
                                input logic [hfs_pkg::DurW-1:0] high,
                                input logic [hfs_pkg::DurW-1:0] top,
                                input logic [hfs_pkg::DurW-1:0] buzz);
    write_reg(hfs_pkg::REG_LOW_LEVEL, low);
    write_reg(hfs_pkg::REG_HIGH_LEVEL, high);
    write_reg(hfs_pkg::REG_MAX_LEVEL, top);
    write_reg(hfs_pkg::REG_LONG_BUZZ_MS, buzz);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_side
    int unsigned stall;
    res_ch.ready <= 1'b0;
    do @(negedge clk); while (rst !== 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = pick_wait();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(negedge clk); while (!res_ch.valid);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    logic [hfs_pkg::FuncW-1:0] func;
    tracker = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    clock_ms = '0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_cmd(hfs_pkg::FUNC_TICK, 32'hFFFF_FFFF);
    send_cmd(FUNC_UNUSED, 32'h0000_0000);
    send_cmd(hfs_pkg::FUNC_DOUBLE, 32'd1000);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd1149);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd1150);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd1300);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd1450);
    send_cmd(hfs_pkg::FUNC_BUTTON, 32'd2000);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd2029);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd2030);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd2090);
    send_cmd(hfs_pkg::FUNC_LONG, 32'd3000);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd3499);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd3500);
    send_cmd(hfs_pkg::FUNC_FAIL, 32'd4000);
    send_cmd(hfs_pkg::FUNC_CALIB, 32'd4100);     // error LED stays on across restart
    send_cmd(hfs_pkg::FUNC_TICK, 32'd4250);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd4310);
    send_cmd(hfs_pkg::FUNC_STOP, 32'd4311);
    send_cmd(hfs_pkg::FUNC_FAIL, 32'hFFFF_FF00);
    send_cmd(hfs_pkg::FUNC_TICK, 32'h0000_0400); // elapsed wraps through zero
    send_cmd(hfs_pkg::FUNC_BUTTON, 32'd5000);
    send_cmd(hfs_pkg::FUNC_TICK, 32'd4000);      // start time ahead of now
    send_cmd(hfs_pkg::FUNC_DOUBLE, 32'd6000);
    send_cmd(hfs_pkg::FUNC_STOP, 32'd6001);
    cmd_ch.valid <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: write_settings(16'd0, 16'd0, 16'd0, 16'd0);
        1: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_settings({8'hA5, hfs_pkg::RST_LOW_LEVEL}, {8'h5A, hfs_pkg::RST_HIGH_LEVEL},
                          {8'h00, hfs_pkg::RST_MAX_LEVEL}, hfs_pkg::RST_LONG_BUZZ_MS);
        default: write_settings(16'($urandom_range(0, 16'hFFFF)),
                                16'($urandom_range(0, 16'hFFFF)),
                                16'($urandom_range(0, 16'hFFFF)),
                                16'($urandom_range(0, 1500)));
      endcase
      quiet = (ph % 3 == 1);
      clock_ms = (ph == 2) ? 32'hFFFF_F000 : $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 40) hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
          func = 3'($urandom_range(hfs_pkg::FUNC_DOUBLE, hfs_pkg::FUNC_CALIB));
          clock_ms += $urandom_range(0, 20);
          send_cmd(func, clock_ms);
        end else if (pick < 9) begin
          send_cmd(hfs_pkg::FUNC_STOP, clock_ms + $urandom_range(0, 20));
        end else if (pick < 11) begin
          send_cmd(FUNC_UNUSED, $urandom());
        end else if (pick < 14) begin
          send_cmd(hfs_pkg::FUNC_TICK, $urandom());
        end else begin
          clock_ms += (pick < 17) ? $urandom_range(0, 70000) : $urandom_range(0, 60);
          send_cmd(hfs_pkg::FUNC_TICK, clock_ms);
        end
      end
      cmd_ch.valid <= 1'b0;
    end

    drain();
    tracker.close_out();
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
sv/hfs_pkg.sv
sv/hfs_chan_if.sv
sv/hfs_cfg_regs.sv
sv/hfs_cue_engine.sv
sv/haptic_feedback_sequencer_core.sv
bench/hfs_tb_pkg.sv
bench/tb_top.sv
